// ----- sv/keyword_hash_table_linear_probe_core_assert.svh -----
// ---------------------------------------------------------------------------
// Keyword table assertion macros
// Concurrent assertion wrappers; they expand to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef KEYWORD_HASH_TABLE_LINEAR_PROBE_CORE_ASSERT_SVH
`define KEYWORD_HASH_TABLE_LINEAR_PROBE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check on every clock edge outside reset
`define KHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included
`define KHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KHT_ASSERT(lbl, prop, msg)
`define KHT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/kht_pkg.sv -----
// ---------------------------------------------------------------------------
// Keyword table package
// Sizes, operation and status codes, queue command type and hash tables.
// ---------------------------------------------------------------------------
package kht_pkg;

  // Table geometry
  localparam int TABLE_SIZE = 31;
  localparam int KEY_BYTES  = 8;
  localparam int TOKEN_BITS = 8;
  localparam int HASH_MULT  = 31;

  localparam int KEY_W   = 8 * KEY_BYTES;
  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int PC_W    = $clog2(TABLE_SIZE + 1);
  localparam int FCNT_W  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

  // Port field widths
  localparam int MODE_W    = 2;
  localparam int KEYIN_W   = 64;
  localparam int TOKIN_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 5;
  localparam int TOKOUT_W  = 8;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 16;

  // Command queue depth, power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INS_H  = 2'd1,
    MODE_INS    = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // Classified item passed from front to back
  typedef struct packed {
    mode_t                  mode;
    logic [KEY_W-1:0]       key;
    logic [TOKEN_BITS-1:0]  tok;
    logic                   hd;
    logic [IDX_W-1:0]       home;
    logic                   empty;
  } cmd_t;

  typedef logic [IDX_W-1:0] h31_tbl_t [TABLE_SIZE];
  typedef logic [IDX_W-1:0] cmod_tbl_t [256];

  // (h * 31) mod size for every h
  function automatic h31_tbl_t build_h31();
    h31_tbl_t t;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      t[i] = IDX_W'((i * HASH_MULT) % TABLE_SIZE);
    end
    return t;
  endfunction

  // c mod size for every byte value
  function automatic cmod_tbl_t build_cmod();
    cmod_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = IDX_W'(i % TABLE_SIZE);
    end
    return t;
  endfunction

  localparam h31_tbl_t  H31_TBL  = build_h31();
  localparam cmod_tbl_t CMOD_TBL = build_cmod();

endpackage

// ----- sv/kht_front.sv -----
// ---------------------------------------------------------------------------
// Keyword table front end
// Accepts items, trims the key at its first zero byte and folds the hash
// one byte per cycle, then pushes a command into the queue.
// ---------------------------------------------------------------------------
module kht_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [kht_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic [kht_pkg::MODE_W-1:0]           in_tuser,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output kht_pkg::cmd_t                        push_cmd
);

  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

  fstate_t                          state_r, state_nxt;
  kht_pkg::mode_t                   mode_r, mode_nxt;
  logic [kht_pkg::KEY_W-1:0]        raw_r, raw_nxt;
  logic [kht_pkg::KEY_W-1:0]        shift_r, shift_nxt;
  logic [kht_pkg::TOKEN_BITS-1:0]   tok_r, tok_nxt;
  logic                             hd_r, hd_nxt;
  logic [kht_pkg::IDX_W-1:0]        h_r, h_nxt;
  logic [kht_pkg::KEY_BYTES-1:0]    mask_r, mask_nxt;
  logic [kht_pkg::KEY_BYTES-1:0]    pos_oh_r, pos_oh_nxt;
  logic [kht_pkg::FCNT_W-1:0]       cnt_r, cnt_nxt;

  logic [7:0]                       byte_c;
  logic [kht_pkg::IDX_W:0]          hsum;
  logic [kht_pkg::IDX_W-1:0]        hred;
  logic [kht_pkg::KEY_W-1:0]        key_m;

  // Hash step: (h*31 + c) mod size from two table reads and one subtract
  assign byte_c = shift_r[7:0];
  assign hsum   = {1'b0, kht_pkg::H31_TBL[h_r]} + {1'b0, kht_pkg::CMOD_TBL[byte_c]};
  assign hred   = (hsum >= (kht_pkg::IDX_W+1)'(kht_pkg::TABLE_SIZE)) ?
                  kht_pkg::IDX_W'(hsum - (kht_pkg::IDX_W+1)'(kht_pkg::TABLE_SIZE)) :
                  kht_pkg::IDX_W'(hsum);

  // Zero the bytes from the terminator on
  always_comb begin
    for (int i = 0; i < kht_pkg::KEY_BYTES; i++) begin
      key_m[i*8 +: 8] = mask_r[i] ? raw_r[i*8 +: 8] : 8'h00;
    end
  end

  assign in_tready  = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);

  always_comb begin
    push_cmd.mode  = mode_r;
    push_cmd.key   = key_m;
    push_cmd.tok   = tok_r;
    push_cmd.hd    = hd_r;
    push_cmd.home  = h_r;
    push_cmd.empty = (mask_r == '0);
  end

  // Next state
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    raw_nxt    = raw_r;
    shift_nxt  = shift_r;
    tok_nxt    = tok_r;
    hd_nxt     = hd_r;
    h_nxt      = h_r;
    mask_nxt   = mask_r;
    pos_oh_nxt = pos_oh_r;
    cnt_nxt    = cnt_r;
    case (state_r)
      F_IDLE: begin
        if (in_tvalid) begin
          mode_nxt   = kht_pkg::mode_t'(in_tuser);
          raw_nxt    = in_tdata[kht_pkg::KEY_W-1:0];
          shift_nxt  = in_tdata[kht_pkg::KEY_W-1:0];
          tok_nxt    = in_tdata[kht_pkg::KEYIN_W +: kht_pkg::TOKEN_BITS];
          hd_nxt     = in_tdata[kht_pkg::KEYIN_W + kht_pkg::TOKIN_W];
          h_nxt      = '0;
          mask_nxt   = '0;
          pos_oh_nxt = kht_pkg::KEY_BYTES'(1);
          cnt_nxt    = '0;
          state_nxt  = (kht_pkg::mode_t'(in_tuser) == kht_pkg::MODE_CLEAR) ? F_PUSH : F_HASH;
        end
      end
      F_HASH: begin
        if (byte_c != 8'h00) begin
          h_nxt    = hred;
          mask_nxt = mask_r | pos_oh_r;
        end
        shift_nxt  = shift_r >> 8;
        pos_oh_nxt = pos_oh_r << 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (byte_c == 8'h00 || cnt_r == kht_pkg::FCNT_W'(kht_pkg::KEY_BYTES - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Hold state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mode_r   <= mode_nxt;
    raw_r    <= raw_nxt;
    shift_r  <= shift_nxt;
    tok_r    <= tok_nxt;
    hd_r     <= hd_nxt;
    h_r      <= h_nxt;
    mask_r   <= mask_nxt;
    pos_oh_r <= pos_oh_nxt;
    cnt_r    <= cnt_nxt;
  end

endmodule

// ----- sv/kht_queue.sv -----
// ---------------------------------------------------------------------------
// Keyword table command queue
// Short FIFO of classified commands between front and back ends.
// ---------------------------------------------------------------------------
module kht_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  kht_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output kht_pkg::cmd_t  pop_cmd
);

  kht_pkg::cmd_t               ent_r [kht_pkg::QDEPTH];
  logic [kht_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [kht_pkg::QCNT_W-1:0]  cnt_r;
  logic                        do_push, do_pop;

  assign push_ready = (cnt_r != kht_pkg::QCNT_W'(kht_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- sv/kht_back.sv -----
// ---------------------------------------------------------------------------
// Keyword table back end
// Walks the slot memory from the home slot, one read per cycle, writes
// inserts and drives the registered result channel.
// ---------------------------------------------------------------------------
module kht_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  kht_pkg::cmd_t                        pop_cmd,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [kht_pkg::OUT_DATA_W-1:0]       out_tdata
);

  typedef enum logic [1:0] {B_IDLE, B_PROBE, B_DONE} bstate_t;

  typedef struct packed {
    logic [kht_pkg::KEY_W-1:0]      key;
    logic [kht_pkg::TOKEN_BITS-1:0] tok;
    logic                           hd;
  } entry_t;

  // Slot memory and valid bits
  entry_t                            mem [kht_pkg::TABLE_SIZE];
  logic [kht_pkg::TABLE_SIZE-1:0]    slot_valid_r;

  bstate_t                           state_r;
  kht_pkg::cmd_t                     cmd_r;
  logic [kht_pkg::IDX_W-1:0]         iss_idx_r;
  logic [kht_pkg::PC_W-1:0]          iss_cnt_r;
  logic [kht_pkg::PC_W-1:0]          cmp_cnt_r;
  logic                              rd_live_r;
  logic [kht_pkg::IDX_W-1:0]         rd_idx_r;
  logic                              rd_valid_r;
  entry_t                            rd_ent_r;
  kht_pkg::status_t                  res_status_r;
  logic [kht_pkg::IDX_W-1:0]         res_idx_r;
  logic [kht_pkg::TOKEN_BITS-1:0]    res_tok_r;
  logic                              res_hd_r;
  logic                              out_tvalid_r;
  logic [kht_pkg::OUT_DATA_W-1:0]    out_tdata_r;

  logic                              hit_c, last_c, issuing_c, wr_en_c;
  logic [kht_pkg::TOKEN_BITS-1:0]    wr_tok_c;
  logic                              wr_hd_c;
  logic [kht_pkg::IDX_W-1:0]         iss_idx_inc;

  assign pop_ready  = (state_r == B_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Compare stage: stop at an empty slot or the matching key
  assign hit_c     = rd_live_r && (!rd_valid_r || rd_ent_r.key == cmd_r.key);
  assign last_c    = rd_live_r &&
                     (cmp_cnt_r == kht_pkg::PC_W'(kht_pkg::TABLE_SIZE - 1));
  assign issuing_c = (state_r == B_PROBE) &&
                     (iss_cnt_r != kht_pkg::PC_W'(kht_pkg::TABLE_SIZE)) && !hit_c && !last_c;
  assign iss_idx_inc = (iss_idx_r == kht_pkg::IDX_W'(kht_pkg::TABLE_SIZE - 1)) ?
                       '0 : iss_idx_r + 1'b1;

  // Insert data: plain insert keeps an old id and drops the handler
  assign wr_en_c  = (state_r == B_PROBE) && hit_c && (cmd_r.mode != kht_pkg::MODE_LOOKUP);
  assign wr_tok_c = (cmd_r.mode == kht_pkg::MODE_INS_H) ? cmd_r.tok :
                    (rd_valid_r ? rd_ent_r.tok : '0);
  assign wr_hd_c  = (cmd_r.mode == kht_pkg::MODE_INS_H) ? cmd_r.hd : 1'b0;

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en_c) begin
      mem[rd_idx_r] <= '{key: cmd_r.key, tok: wr_tok_c, hd: wr_hd_c};
    end
    rd_ent_r <= mem[iss_idx_r];
  end

  // Control state, valid bits and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      slot_valid_r <= '0;
      rd_live_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      rd_live_r <= issuing_c;
      // Drop a taken result; B_DONE reloads the register itself
      if (out_tvalid_r && out_tready && state_r != B_DONE) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            cmd_r     <= pop_cmd;
            iss_idx_r <= pop_cmd.home;
            iss_cnt_r <= '0;
            cmp_cnt_r <= '0;
            res_idx_r <= '0;
            res_tok_r <= '0;
            res_hd_r  <= 1'b0;
            if (pop_cmd.mode == kht_pkg::MODE_CLEAR) begin
              slot_valid_r <= '0;
              res_status_r <= kht_pkg::ST_OK;
              state_r      <= B_DONE;
            end else if (pop_cmd.empty) begin
              res_status_r <= kht_pkg::ST_NOT_FOUND;
              state_r      <= B_DONE;
            end else begin
              state_r <= B_PROBE;
            end
          end
        end
        B_PROBE: begin
          if (issuing_c) begin
            iss_idx_r <= iss_idx_inc;
            iss_cnt_r <= iss_cnt_r + 1'b1;
          end
          if (hit_c) begin
            state_r <= B_DONE;
            if (cmd_r.mode == kht_pkg::MODE_LOOKUP) begin
              if (rd_valid_r) begin
                res_status_r <= kht_pkg::ST_OK;
                res_idx_r    <= rd_idx_r;
                res_tok_r    <= rd_ent_r.tok;
                res_hd_r     <= rd_ent_r.hd;
              end else begin
                res_status_r <= kht_pkg::ST_NOT_FOUND;
              end
            end else begin
              slot_valid_r[rd_idx_r] <= 1'b1;
              res_status_r <= kht_pkg::ST_OK;
              res_idx_r    <= rd_idx_r;
              res_tok_r    <= wr_tok_c;
              res_hd_r     <= wr_hd_c;
            end
          end else if (last_c) begin
            state_r      <= B_DONE;
            res_status_r <= (cmd_r.mode == kht_pkg::MODE_LOOKUP) ?
                            kht_pkg::ST_NOT_FOUND : kht_pkg::ST_FULL;
          end else if (rd_live_r) begin
            cmp_cnt_r <= cmp_cnt_r + 1'b1;
          end
        end
        B_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {res_hd_r,
                             kht_pkg::TOKOUT_W'(res_tok_r),
                             kht_pkg::SLOT_W'(res_idx_r),
                             res_status_r};
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
    // Read stage bookkeeping
    rd_idx_r   <= iss_idx_r;
    rd_valid_r <= slot_valid_r[iss_idx_r];
  end

endmodule

// ----- sv/keyword_hash_table_linear_probe_core.sv -----
// ---------------------------------------------------------------------------
// Keyword hash table, linear probing
// Open-addressed keyword table: clear, insert, insert without handler and
// lookup on keys of up to eight bytes, one result per item.
// ---------------------------------------------------------------------------
//  Channel  Ports                     Contents
//  in       in_tvalid/tready/tdata/   mode in tuser; key, token id, handler
//           tuser                     flag in tdata
//  out      out_tvalid/tready/tdata   status, slot index, token id, handler
//
//  Front end: an accept state, a hash step per key byte up to the
//  terminator (at most KEY_BYTES), then a push state. Back end: a pop from
//  the queue, a probe walk from the home slot (one slot memory read per
//  cycle) and a result step. Front and back overlap through a 2-entry
//  command queue. Reset (synchronous, rst_n low) empties the table at once
//  through the valid bits; there is no clearing pass. A stalled result
//  holds the back end while the front end keeps filling the queue.
// ---------------------------------------------------------------------------
`include "keyword_hash_table_linear_probe_core_assert.svh"

module keyword_hash_table_linear_probe_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [63:0] key_chars, [71:64] token_id, [72] has_handler, [79:73] zero
  input  logic [kht_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] mode
  input  logic [kht_pkg::MODE_W-1:0]         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [6:2] slot_index, [14:7] found_token_id, [15] found_handler
  output logic [kht_pkg::OUT_DATA_W-1:0]     out_tdata
);

  logic           fe_push_valid, q_push_ready;
  kht_pkg::cmd_t  fe_cmd;
  logic           q_pop_valid, be_pop_ready;
  kht_pkg::cmd_t  q_cmd;

  // Accept and classify
  kht_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (fe_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (fe_cmd)
  );

  // Decouple front from back
  kht_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_push_valid),
    .push_ready (q_push_ready),
    .push_cmd   (fe_cmd),
    .pop_valid  (q_pop_valid),
    .pop_ready  (be_pop_ready),
    .pop_cmd    (q_cmd)
  );

  // Probe, update and answer
  kht_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (q_pop_valid),
    .pop_ready  (be_pop_ready),
    .pop_cmd    (q_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `KHT_ASSERT(a_front_holds_push, fe_push_valid && !q_push_ready |=> fe_push_valid, "front dropped a command while the queue was full")
  `KHT_ASSERT(a_busy_after_accept, in_tvalid && in_tready |=> !in_tready, "front accepted a transaction while busy")
  `KHT_ASSERT(a_miss_fields_zero, out_tvalid && out_tdata[1:0] != kht_pkg::ST_OK |-> out_tdata[15:2] == '0, "failed result carries nonzero fields")
  `KHT_ASSERT_ALWAYS(a_reset_no_result, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

// ----- test/keyword_hash_table_linear_probe_core_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Keyword hash table testbench
// Streams clear, insert, handler-less insert and lookup transactions into the
// table and checks every reply against a table predictor kept in the bench.
// Both channels idle at random outside a quiet window; the reply side holds
// off once for a long stretch so that the core fills up and stalls its input.
// ---------------------------------------------------------------------------
module keyword_hash_table_linear_probe_core_tb;

  localparam int QUIET_FROM  = 8000;
  localparam int QUIET_TO    = 16000;
  localparam int HOLD_AT     = 600;
  localparam int HOLD_CYCLES = 400;
  localparam int OP_TARGET   = 1950;

  typedef struct packed {
    kht_pkg::mode_t                mode;
    logic [kht_pkg::KEYIN_W-1:0]   chars;
    logic [kht_pkg::TOKIN_W-1:0]   token;
    logic                          handler;
  } table_op_t;

  typedef struct packed {
    kht_pkg::status_t              status;
    logic [kht_pkg::SLOT_W-1:0]    slot;
    logic [kht_pkg::TOKOUT_W-1:0]  token;
    logic                          handler;
  } table_reply_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [kht_pkg::IN_DATA_W-1:0]   in_tdata = '0;
  logic [kht_pkg::MODE_W-1:0]      in_tuser = kht_pkg::MODE_CLEAR;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [kht_pkg::OUT_DATA_W-1:0]  out_tdata;

  keyword_hash_table_linear_probe_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predicted table contents
  bit                              entry_used [kht_pkg::TABLE_SIZE];
  logic [kht_pkg::KEYIN_W-1:0]     entry_key  [kht_pkg::TABLE_SIZE];
  logic [kht_pkg::TOKOUT_W-1:0]    entry_tok  [kht_pkg::TABLE_SIZE];
  logic                            entry_hd   [kht_pkg::TABLE_SIZE];

  table_op_t                       pending_ops [$];
  table_reply_t                    expected_replies [$];
  logic [kht_pkg::KEYIN_W-1:0]     key_pool [$];

  int                     mismatches = 0;
  int                     replies_seen = 0;
  int                     cycle_count = 0;
  bit                     in_taken = 1'b0;
  int                     hold_left = 0;
  bit                     hold_done = 1'b0;
  wire                    quiet = cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;

  initial begin
    forever #10 clk = ~clk;
  end

  // Apply one transaction to the predicted table and return its reply
  function automatic table_reply_t apply_table_op(input table_op_t op);
    logic [kht_pkg::KEYIN_W-1:0] key;
    logic [7:0]         c;
    int                 h;
    int                 idx;
    int                 len;
    bit                 hit;
    table_reply_t       r;
    r = '0;
    r.status = kht_pkg::ST_OK;
    key = '0;
    h = 0;
    hit = 1'b0;
    if (op.mode == kht_pkg::MODE_CLEAR) begin
      for (int i = 0; i < kht_pkg::TABLE_SIZE; i++) entry_used[i] = 1'b0;
      return r;
    end
    // Fold the hash over the bytes up to the terminator
    for (len = 0; len < kht_pkg::KEY_BYTES; len++) begin
      c = op.chars[8*len +: 8];
      if (c == 8'd0) break;
      key[8*len +: 8] = c;
      h = (h * kht_pkg::HASH_MULT + c) % kht_pkg::TABLE_SIZE;
    end
    if (len == 0) begin
      r.status = kht_pkg::ST_NOT_FOUND;
      return r;
    end
    // Walk forward from the home slot to an empty slot or the key
    idx = h;
    for (int n = 0; n < kht_pkg::TABLE_SIZE; n++) begin
      if (!entry_used[idx] || entry_key[idx] == key) begin
        hit = 1'b1;
        break;
      end
      idx = (idx + 1) % kht_pkg::TABLE_SIZE;
    end
    if (op.mode == kht_pkg::MODE_LOOKUP) begin
      if (hit && entry_used[idx]) begin
        r.slot    = kht_pkg::SLOT_W'(idx);
        r.token   = entry_tok[idx];
        r.handler = entry_hd[idx];
      end else begin
        r.status = kht_pkg::ST_NOT_FOUND;
      end
      return r;
    end
    if (!hit) begin
      r.status = kht_pkg::ST_FULL;
      return r;
    end
    // Handler-less insert keeps an old id but zeroes it in a fresh slot
    if (op.mode == kht_pkg::MODE_INS_H) begin
      entry_tok[idx] = op.token;
      entry_hd[idx]  = op.handler;
    end else begin
      if (!entry_used[idx]) entry_tok[idx] = '0;
      entry_hd[idx] = 1'b0;
    end
    entry_used[idx] = 1'b1;
    entry_key[idx]  = key;
    r.slot    = kht_pkg::SLOT_W'(idx);
    r.token   = entry_tok[idx];
    r.handler = entry_hd[idx];
    return r;
  endfunction

  // Random key of 1 to 8 nonzero bytes, zero above its end
  function automatic logic [kht_pkg::KEYIN_W-1:0] random_key();
    logic [kht_pkg::KEYIN_W-1:0] k;
    int                 len;
    k = '0;
    len = $urandom_range(1, kht_pkg::KEY_BYTES);
    for (int b = 0; b < len; b++) k[8*b +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // Fill the bytes past the terminator with junk half of the time
  function automatic logic [kht_pkg::KEYIN_W-1:0] add_tail(
      input logic [kht_pkg::KEYIN_W-1:0] k);
    logic [kht_pkg::KEYIN_W-1:0] r;
    int                 pos;
    r = k;
    pos = kht_pkg::KEY_BYTES;
    for (int b = 0; b < kht_pkg::KEY_BYTES; b++) begin
      if (k[8*b +: 8] == 8'd0) begin
        pos = b;
        break;
      end
    end
    if ($urandom_range(0, 1) == 1) begin
      for (int b = pos + 1; b < kht_pkg::KEY_BYTES; b++) r[8*b +: 8] = 8'($urandom);
    end
    return r;
  endfunction

  task automatic push_op(input kht_pkg::mode_t m,
                         input logic [kht_pkg::KEYIN_W-1:0] chars,
                         input logic [kht_pkg::TOKIN_W-1:0] tok, input logic hd);
    table_op_t op;
    op.mode    = m;
    op.chars   = chars;
    op.token   = tok;
    op.handler = hd;
    pending_ops.push_back(op);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Reset, stimulus and end of run
  initial begin
    int pool_size;
    int phase_len;
    int pick;
    logic [kht_pkg::KEYIN_W-1:0] k;

    // Directed: clear, misses, extremes, collisions, wrap, empty keys
    push_op(kht_pkg::MODE_CLEAR, {$urandom, $urandom}, 8'hA5, 1'b1);
    push_op(kht_pkg::MODE_LOOKUP, 64'h41, 8'h00, 1'b0);
    push_op(kht_pkg::MODE_INS_H, '1, 8'hFF, 1'b1);
    push_op(kht_pkg::MODE_LOOKUP, '1, 8'h00, 1'b0);
    push_op(kht_pkg::MODE_INS_H, 64'h01, 8'h00, 1'b0);
    push_op(kht_pkg::MODE_INS, 64'h0000_0000_0000_4241, 8'hFF, 1'b1);
    push_op(kht_pkg::MODE_INS_H, 64'h0000_0000_0043_4241, 8'h5A, 1'b1);
    push_op(kht_pkg::MODE_INS, 64'h0000_0000_0043_4241, 8'h11, 1'b1);
    push_op(kht_pkg::MODE_LOOKUP, 64'h0000_0000_0043_4241, 8'h00, 1'b0);
    push_op(kht_pkg::MODE_CLEAR, '0, 8'h00, 1'b0);
    push_op(kht_pkg::MODE_INS_H, 64'h04, 8'h01, 1'b1);
    push_op(kht_pkg::MODE_INS_H, 64'h23, 8'h02, 1'b0);
    push_op(kht_pkg::MODE_INS_H, 64'h0000_0000_0000_4261, 8'h03, 1'b1);
    push_op(kht_pkg::MODE_LOOKUP, 64'h0000_0000_0000_4261, 8'h00, 1'b0);
    push_op(kht_pkg::MODE_INS_H, 64'h1E, 8'h80, 1'b1);
    push_op(kht_pkg::MODE_INS_H, 64'h3D, 8'h7F, 1'b0);
    push_op(kht_pkg::MODE_LOOKUP, 64'h3D, 8'h00, 1'b0);
    push_op(kht_pkg::MODE_INS_H, 64'hFFFF_FF00_4142_4344, 8'h33, 1'b1);
    push_op(kht_pkg::MODE_LOOKUP, 64'h1234_5600_4142_4344, 8'h00, 1'b0);
    push_op(kht_pkg::MODE_INS_H, 64'hDEAD_BEEF_CAFE_F000, 8'h44, 1'b1);
    push_op(kht_pkg::MODE_INS, 64'h8000_0000_0000_0000, 8'h00, 1'b0);
    push_op(kht_pkg::MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 8'h00, 1'b0);

    // Random phases over key pools of varied size; large pools fill the table
    while (pending_ops.size() < OP_TARGET - 22) begin
      if ($urandom_range(0, 1) == 1) push_op(kht_pkg::MODE_CLEAR, {$urandom, $urandom},
                                             8'($urandom), 1'($urandom));
      case ($urandom_range(0, 4))
        0: pool_size = 3;
        1: pool_size = 12;
        2: pool_size = 24;
        3: pool_size = 40;
        default: pool_size = 48;
      endcase
      key_pool.delete();
      for (int i = 0; i < pool_size; i++) key_pool.push_back(random_key());
      phase_len = $urandom_range(40, 120);
      for (int i = 0; i < phase_len; i++) begin
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) k = random_key();
        else k = key_pool[$urandom_range(0, pool_size - 1)];
        k = add_tail(k);
        if (pick < 2) begin
          push_op(kht_pkg::MODE_CLEAR, {$urandom, $urandom}, 8'($urandom), 1'($urandom));
        end else if (pick < 6) begin
          push_op(kht_pkg::mode_t'($urandom_range(1, 3)), {$urandom, $urandom} & ~64'hFF,
                  8'($urandom), 1'($urandom));
        end else if (pick < 40) begin
          push_op(kht_pkg::MODE_INS_H, k, 8'($urandom), 1'($urandom));
        end else if (pick < 55) begin
          push_op(kht_pkg::MODE_INS, k, 8'($urandom), 1'($urandom));
        end else begin
          push_op(kht_pkg::MODE_LOOKUP, k, 8'($urandom), 1'($urandom));
        end
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain the input, then the replies, then let the core settle
    while (pending_ops.size() != 0 || in_tvalid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (64) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Sample input transactions and predict their replies
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_replies.push_back(apply_table_op({kht_pkg::mode_t'(in_tuser),
                                                 in_tdata[63:0],
                                                 in_tdata[71:64], in_tdata[72]}));
    end
  end

  // Offer the next item once the current one is taken, idling at random
  always @(negedge clk) begin
    table_op_t op;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_ops.size() > 0 && (quiet || $urandom_range(0, 99) >= 6)) begin
        op = pending_ops.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {7'd0, op.handler, op.token, op.chars};
        in_tuser  <= op.mode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Accept replies, with one long hold-off to back the core up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && replies_seen >= HOLD_AT) begin
      hold_done  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && (quiet || $urandom_range(0, 99) >= 6);
    end
  end

  // Check each reply against the oldest prediction
  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected reply", 64'(out_tdata), 64'd0);
      end else begin
        want = expected_replies.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", 64'(out_tdata[1:0]), 64'(want.status));
        if (out_tdata[6:2] !== want.slot)
          report_mismatch("slot_index", 64'(out_tdata[6:2]), 64'(want.slot));
        if (out_tdata[14:7] !== want.token)
          report_mismatch("found_token_id", 64'(out_tdata[14:7]), 64'(want.token));
        if (out_tdata[15] !== want.handler)
          report_mismatch("found_handler", 64'(out_tdata[15]), 64'(want.handler));
      end
    end
  end

endmodule
